// File: src/ffba_pkg.sv
// shared constants and types of the first-fit block allocator
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int PTR_W        = IDX_W + 1;
  localparam int ADDR_W       = 21;
  localparam int SIZE_W       = ADDR_W + 1;
  localparam int HEADER_BYTES = 24;
  localparam int HEAP_BYTES   = 1048576;
  localparam int ALIGN_BYTES  = 8;
  localparam int GUARD_MAX    = 2 * MAX_BLOCKS + 2;
  localparam int GUARD_W      = $clog2(GUARD_MAX + 1);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_BLOCKS);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic [PTR_W-1:0]  next;
  } entry_t;

endpackage

// File: src/ffba_mem.sv
// block table memory: start, size and link of every slot
module ffba_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ffba_pkg::IDX_W-1:0] waddr,
  input  ffba_pkg::entry_t          wdata,
  input  logic                      re,
  input  logic [ffba_pkg::IDX_W-1:0] raddr,
  output ffba_pkg::entry_t          rdata
);
  import ffba_pkg::*;

  entry_t mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/first_fit_block_allocator.sv
// top level of the first-fit block allocator: request sequencer and flags
//
// usage
//   req channel (req_valid/req_ready/req): one item per allocate or release
//   rsp channel (rsp_valid/rsp_ready/rsp): exactly one item per request, in order
//   cfg_we/cfg_data: user writes heap_limit only while idle (not enforced)
// timing
//   requests are handled one at a time; req_ready is high only when idle
//   allocate: one table read per entry visited, a re-check after a merge
//   counting as a visit; merges, splits and growth add their table writes
//   release: a pipelined scan of the table at one entry per cycle, and a second
//   scan of the same kind when the tail shrinks
//   reads of the table memory are registered
// reset
//   synchronous rst empties the table (used and free flags cleared, list ends
//   null), zeroes the break and sets heap_limit to its full value
// stalls
//   the result sits in an output register; while rsp_ready is low one more
//   request may be taken and waits finished until the register frees
module first_fit_block_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  ffba_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output ffba_pkg::rsp_t               rsp,
  input  logic                         cfg_we,
  input  logic [ffba_pkg::ADDR_W-1:0]  cfg_data
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_CUR, S_SPLIT2, S_MERGE, S_GROW, S_GROW2,
    S_RSCAN, S_RHIT, S_PRED, S_DONE
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   size;
  logic [ADDR_W-1:0]   baddr;
  logic [PTR_W-1:0]    cur;
  logic [GUARD_W-1:0]  guard;
  entry_t              ce;
  logic [IDX_W-1:0]    slot;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    chk_i;
  logic                chk_v;
  logic [IDX_W-1:0]    hit;
  rsp_t                res;
  logic [MAX_BLOCKS-1:0] used;
  logic [MAX_BLOCKS-1:0] freeb;
  logic [PTR_W-1:0]    head;
  logic [PTR_W-1:0]    tail;
  logic [ADDR_W-1:0]   brk;
  logic [ADDR_W-1:0]   limit;

  // table memory port
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;
  entry_t              rdata;

  ffba_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // lowest unused slot
  logic [IDX_W-1:0] free_slot;
  logic             slot_found;
  always_comb begin
    free_slot  = '0;
    slot_found = 1'b0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot  = IDX_W'(i);
        slot_found = 1'b1;
      end
    end
  end

  // request size rounded up to the alignment, kept one bit wider
  logic [SIZE_W-1:0] req_round;
  assign req_round = (SIZE_W'(req.req_size) + SIZE_W'(ALIGN_BYTES - 1)) &
                     ~SIZE_W'(ALIGN_BYTES - 1);

  logic [IDX_W-1:0] cur_idx;
  logic             cur_ok;
  logic             head_ok;
  logic             tail_ok;
  assign cur_idx = cur[IDX_W-1:0];
  assign cur_ok  = !cur[PTR_W-1] && used[cur_idx];
  assign head_ok = !head[PTR_W-1] && used[head[IDX_W-1:0]];
  assign tail_ok = !tail[PTR_W-1] && used[tail[IDX_W-1:0]];

  // fit tests on the entry just read
  logic [SIZE_W:0] s_ext;
  logic [SIZE_W:0] size_hdr;
  logic            fits;
  logic            big;
  logic            nx_ok;
  assign s_ext    = (SIZE_W + 1)'(rdata.size);
  assign size_hdr = (SIZE_W + 1)'(size) + (SIZE_W + 1)'(HEADER_BYTES);
  assign big      = s_ext > (SIZE_W + 1)'(size);
  assign fits     = (s_ext == (SIZE_W + 1)'(size)) || (big && s_ext < size_hdr);
  assign nx_ok    = !rdata.next[PTR_W-1] && used[rdata.next[IDX_W-1:0]] &&
                    freeb[rdata.next[IDX_W-1:0]];

  // growth bound
  logic [ADDR_W-1:0] lim;
  logic              no_room;
  assign lim     = (limit < ADDR_W'(HEAP_BYTES)) ? limit : ADDR_W'(HEAP_BYTES);
  assign no_room = (brk > lim) || (size_hdr > (SIZE_W + 1)'(lim - brk));

  // release tests
  logic rel_match;
  logic pred_match;
  logic ends_at_brk;
  assign rel_match   = chk_v && used[chk_i] && (rdata.start == baddr);
  assign pred_match  = chk_v && used[chk_i] && (chk_i != hit) &&
                       (rdata.next == {1'b0, hit});
  assign ends_at_brk = (SIZE_W'(ce.start) + SIZE_W'(ce.size)) == SIZE_W'(brk);

  assign req_ready = (state == S_IDLE);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_idx;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = cur_idx;
    unique case (state)
      S_WALK: begin
        mem_re = (guard < GUARD_W'(GUARD_MAX)) && cur_ok;
      end
      S_CUR: begin
        if (freeb[cur_idx] && !fits && big && slot_found) begin
          // free remainder behind the handed-out front part
          mem_we          = 1'b1;
          mem_waddr       = free_slot;
          mem_wdata.start = ADDR_W'(SIZE_W'(rdata.start) + size +
                                    SIZE_W'(HEADER_BYTES));
          mem_wdata.size  = ADDR_W'(SIZE_W'(rdata.size) - size -
                                    SIZE_W'(HEADER_BYTES));
          mem_wdata.next  = rdata.next;
        end else if (freeb[cur_idx] && !fits && !big && nx_ok) begin
          mem_re    = 1'b1;
          mem_raddr = rdata.next[IDX_W-1:0];
        end
      end
      S_SPLIT2: begin
        mem_we    = 1'b1;
        mem_wdata = '{start: ce.start, size: size[ADDR_W-1:0], next: {1'b0, slot}};
      end
      S_MERGE: begin
        mem_we         = 1'b1;
        mem_wdata.start = ce.start;
        mem_wdata.size  = ADDR_W'(SIZE_W'(ce.size) + SIZE_W'(rdata.size) +
                                  SIZE_W'(HEADER_BYTES));
        mem_wdata.next  = rdata.next;
      end
      S_GROW: begin
        if (slot_found && !no_room) begin
          mem_we    = 1'b1;
          mem_waddr = free_slot;
          mem_wdata = '{start: brk + ADDR_W'(HEADER_BYTES),
                        size: size[ADDR_W-1:0], next: NIL};
          mem_re    = tail_ok;
          mem_raddr = tail[IDX_W-1:0];
        end
      end
      S_GROW2: begin
        mem_we    = 1'b1;
        mem_waddr = tail[IDX_W-1:0];
        mem_wdata = '{start: rdata.start, size: rdata.size, next: {1'b0, slot}};
      end
      S_RSCAN: begin
        mem_re    = !rel_match && !(chk_v && chk_i == IDX_W'(MAX_BLOCKS - 1));
        mem_raddr = idx;
      end
      S_PRED: begin
        if (pred_match) begin
          mem_we    = 1'b1;
          mem_waddr = chk_i;
          mem_wdata = '{start: rdata.start, size: rdata.size, next: NIL};
        end else begin
          mem_re    = !(chk_v && chk_i == IDX_W'(MAX_BLOCKS - 1));
          mem_raddr = idx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      freeb     <= '0;
      head      <= NIL;
      tail      <= NIL;
      brk       <= '0;
      limit     <= ADDR_W'(HEAP_BYTES);
      rsp_valid <= 1'b0;
      guard     <= '0;
      chk_v     <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      // in S_DONE the output register is refilled instead
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            size  <= req_round;
            baddr <= req.block_addr;
            cur   <= head;
            guard <= '0;
            idx   <= '0;
            chk_v <= 1'b0;
            if (req.cmd == CMD_RELEASE) begin
              if (req.block_addr == '0) begin
                res   <= '{addr: '0, status: ST_OK};
                state <= S_DONE;
              end else begin
                state <= S_RSCAN;
              end
            end else if (req_round == '0) begin
              res   <= '{addr: '0, status: ST_BAD};
              state <= S_DONE;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (guard >= GUARD_W'(GUARD_MAX) || !cur_ok) begin
            state <= S_GROW;
          end else begin
            state <= S_CUR;
          end
        end
        S_CUR: begin
          ce <= rdata;
          if (!freeb[cur_idx]) begin
            cur   <= rdata.next;
            guard <= guard + 1'b1;
            state <= S_WALK;
          end else if (fits) begin
            freeb[cur_idx] <= 1'b0;
            res   <= '{addr: rdata.start, status: ST_OK};
            state <= S_DONE;
          end else if (big) begin
            if (slot_found) begin
              used[free_slot]  <= 1'b1;
              freeb[free_slot] <= 1'b1;
              slot             <= free_slot;
              if (cur == tail) begin
                tail <= {1'b0, free_slot};
              end
              state <= S_SPLIT2;
            end else begin
              // table full: the block goes out whole
              freeb[cur_idx] <= 1'b0;
              res   <= '{addr: rdata.start, status: ST_OK};
              state <= S_DONE;
            end
          end else if (nx_ok) begin
            state <= S_MERGE;
          end else begin
            cur   <= rdata.next;
            guard <= guard + 1'b1;
            state <= S_WALK;
          end
        end
        S_SPLIT2: begin
          freeb[cur_idx] <= 1'b0;
          res   <= '{addr: ce.start, status: ST_OK};
          state <= S_DONE;
        end
        S_MERGE: begin
          // absorbed successor leaves the table, current block is checked again
          if (ce.next == tail) begin
            tail <= cur;
          end
          used[ce.next[IDX_W-1:0]]  <= 1'b0;
          freeb[ce.next[IDX_W-1:0]] <= 1'b0;
          guard <= guard + 1'b1;
          state <= S_WALK;
        end
        S_GROW: begin
          if (!slot_found) begin
            res   <= '{addr: '0, status: ST_FULL};
            state <= S_DONE;
          end else if (no_room) begin
            res   <= '{addr: '0, status: ST_NOSPACE};
            state <= S_DONE;
          end else begin
            used[free_slot]  <= 1'b1;
            freeb[free_slot] <= 1'b0;
            slot             <= free_slot;
            if (!head_ok) begin
              head <= {1'b0, free_slot};
            end
            res <= '{addr: brk + ADDR_W'(HEADER_BYTES), status: ST_OK};
            brk <= ADDR_W'(SIZE_W'(brk) + size + SIZE_W'(HEADER_BYTES));
            if (tail_ok) begin
              state <= S_GROW2;
            end else begin
              tail  <= {1'b0, free_slot};
              state <= S_DONE;
            end
          end
        end
        S_GROW2: begin
          tail  <= {1'b0, slot};
          state <= S_DONE;
        end
        S_RSCAN: begin
          if (rel_match) begin
            hit   <= chk_i;
            ce    <= rdata;
            state <= S_RHIT;
          end else if (chk_v && chk_i == IDX_W'(MAX_BLOCKS - 1)) begin
            res   <= '{addr: '0, status: ST_BAD};
            state <= S_DONE;
          end else begin
            chk_i <= idx;
            chk_v <= 1'b1;
            idx   <= idx + 1'b1;
          end
        end
        S_RHIT: begin
          res <= '{addr: '0, status: ST_OK};
          if (tail == {1'b0, hit} && ends_at_brk) begin
            if (head == tail) begin
              head       <= NIL;
              tail       <= NIL;
              brk        <= brk - ADDR_W'(HEADER_BYTES) - ce.size;
              used[hit]  <= 1'b0;
              freeb[hit] <= 1'b0;
              state      <= S_DONE;
            end else begin
              idx   <= '0;
              chk_v <= 1'b0;
              state <= S_PRED;
            end
          end else begin
            freeb[hit] <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_PRED: begin
          if (pred_match || (chk_v && chk_i == IDX_W'(MAX_BLOCKS - 1))) begin
            if (pred_match) begin
              tail <= {1'b0, chk_i};
            end
            brk        <= brk - ADDR_W'(HEADER_BYTES) - ce.size;
            used[hit]  <= 1'b0;
            freeb[hit] <= 1'b0;
            state      <= S_DONE;
          end else begin
            chk_i <= idx;
            chk_v <= 1'b1;
            idx   <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // the break never passes the heap size
  a_brk_bound: assert property (@(posedge clk) disable iff (rst)
    brk <= ADDR_W'(HEAP_BYTES))
    else $error("heap break beyond heap size");

  // the walk guard stops the chain walk
  a_guard_bound: assert property (@(posedge clk) disable iff (rst)
    guard <= GUARD_W'(GUARD_MAX))
    else $error("walk guard overrun");

  // a new block is only written into an unused slot
  a_grow_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_GROW && mem_we) |-> !used[mem_waddr])
    else $error("growth overwrites a used slot");

  // a result leaves only through a handshake
  a_rsp_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(rsp_valid) |-> $past(rsp_ready))
    else $error("result dropped without handshake");
`endif

endmodule

// File: dv/testbench.sv
// self-checking testbench of the first-fit block allocator: driver, monitor and allocator predictor
module testbench;
  import ffba_pkg::*;

  localparam int DRAIN_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_data = '0;

  first_fit_block_allocator uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow heap: table, chain ends, break and limit register
  int unsigned sh_size [MAX_BLOCKS];
  int unsigned sh_start[MAX_BLOCKS];
  int unsigned sh_next [MAX_BLOCKS];
  bit          sh_free [MAX_BLOCKS];
  bit          sh_used [MAX_BLOCKS];
  int unsigned sh_head, sh_tail, sh_break, sh_limit;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic [ADDR_W-1:0] live_addrs[$];
  int   errors = 0;
  bit   quiet = 1'b0;
  bit   req_taken = 1'b0;
  int   req_idle = 0;
  int   rsp_idle = 0;

  function automatic bit in_use(int unsigned i);
    return i < MAX_BLOCKS && sh_used[i];
  endfunction

  function automatic int unsigned free_slot();
    for (int i = 0; i < MAX_BLOCKS; i++) if (!sh_used[i]) return i;
    return MAX_BLOCKS;
  endfunction

  function automatic rsp_t mk_rsp(int unsigned a, logic [1:0] st);
    rsp_t o;
    o.addr = a[ADDR_W-1:0];
    o.status = st;
    return o;
  endfunction

  function automatic rsp_t alloc_block(int unsigned req_bytes);
    int unsigned want, cur, s, slot, nx, lim, total;
    want = req_bytes;
    if (want % ALIGN_BYTES != 0) want += ALIGN_BYTES - want % ALIGN_BYTES;
    if (want == 0) return mk_rsp(0, ST_BAD);
    cur = sh_head;
    // first-fit walk; too-small free blocks swallow a free successor and are re-checked
    for (int guard = 0; guard < GUARD_MAX && in_use(cur); guard++) begin
      if (sh_free[cur]) begin
        s = sh_size[cur];
        if (s == want || (s > want && s < want + HEADER_BYTES)) begin
          sh_free[cur] = 1'b0;
          return mk_rsp(sh_start[cur], ST_OK);
        end
        if (s > want) begin
          // split unless the table is full, then hand out whole
          slot = free_slot();
          if (slot != MAX_BLOCKS) begin
            sh_used[slot] = 1'b1;
            sh_free[slot] = 1'b1;
            sh_start[slot] = (sh_start[cur] + want + HEADER_BYTES) & 32'h1FFFFF;
            sh_size[slot] = s - want - HEADER_BYTES;
            sh_next[slot] = sh_next[cur];
            sh_size[cur] = want;
            sh_next[cur] = slot;
            if (cur == sh_tail) sh_tail = slot;
          end
          sh_free[cur] = 1'b0;
          return mk_rsp(sh_start[cur], ST_OK);
        end
        nx = sh_next[cur];
        if (in_use(nx) && sh_free[nx]) begin
          sh_size[cur] = (s + sh_size[nx] + HEADER_BYTES) & 32'h1FFFFF;
          sh_next[cur] = sh_next[nx];
          if (nx == sh_tail) sh_tail = cur;
          sh_used[nx] = 1'b0;
          sh_free[nx] = 1'b0;
          continue;
        end
      end
      cur = sh_next[cur];
    end
    // grow the break
    slot = free_slot();
    if (slot == MAX_BLOCKS) return mk_rsp(0, ST_FULL);
    lim = (sh_limit < HEAP_BYTES) ? sh_limit : HEAP_BYTES;
    total = HEADER_BYTES + want;
    if (sh_break > lim || total > lim - sh_break) return mk_rsp(0, ST_NOSPACE);
    sh_used[slot] = 1'b1;
    sh_free[slot] = 1'b0;
    sh_start[slot] = sh_break + HEADER_BYTES;
    sh_size[slot] = want;
    sh_next[slot] = MAX_BLOCKS;
    if (!in_use(sh_head)) sh_head = slot;
    if (in_use(sh_tail)) sh_next[sh_tail] = slot;
    sh_tail = slot;
    sh_break += total;
    return mk_rsp(sh_start[slot], ST_OK);
  endfunction

  function automatic rsp_t release_block(int unsigned a);
    int unsigned hit;
    hit = MAX_BLOCKS;
    if (a == 0) return mk_rsp(0, ST_OK);
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (sh_used[i] && sh_start[i] == a) begin
        hit = i;
        break;
      end
    end
    if (hit == MAX_BLOCKS) return mk_rsp(0, ST_BAD);
    if (hit == sh_tail && sh_start[hit] + sh_size[hit] == sh_break) begin
      // tail ends at the break: pull the break back and unlink
      if (sh_head == sh_tail) begin
        sh_head = MAX_BLOCKS;
        sh_tail = MAX_BLOCKS;
      end else begin
        for (int i = 0; i < MAX_BLOCKS; i++) begin
          if (sh_used[i] && i != hit && sh_next[i] == hit) begin
            sh_next[i] = MAX_BLOCKS;
            sh_tail = i;
            break;
          end
        end
      end
      sh_break -= HEADER_BYTES + sh_size[hit];
      sh_used[hit] = 1'b0;
      sh_free[hit] = 1'b0;
      return mk_rsp(0, ST_OK);
    end
    sh_free[hit] = 1'b1;
    return mk_rsp(0, ST_OK);
  endfunction

  initial begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      sh_size[i] = 0; sh_start[i] = 0; sh_next[i] = 0; sh_free[i] = 1'b0; sh_used[i] = 1'b0;
    end
    sh_head = MAX_BLOCKS;
    sh_tail = MAX_BLOCKS;
    sh_break = 0;
    sh_limit = HEAP_BYTES;
  end

  // monitor: check results, then predict newly accepted items
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("result with no item outstanding: addr %0d status %0d", rsp.addr, rsp.status);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.addr !== want.addr) begin
            $error("addr: expected %0d, actual %0d", want.addr, rsp.addr);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            errors++;
          end
        end
      end
      if (cfg_we) sh_limit = 32'(cfg_data);
      if (req_valid && req_ready) begin
        if (req.cmd == CMD_RELEASE) want = release_block(32'(req.block_addr));
        else want = alloc_block(32'(req.req_size));
        if (req.cmd == CMD_ALLOC && want.status == ST_OK) live_addrs.push_back(want.addr);
        expected_rsps.push_back(want);
      end
    end
    req_taken <= req_valid && req_ready && !rst;
  end

  // driver: request side, holds an item until taken, idles in bursts
  always @(negedge clk) begin
    if (!rst && !(req_valid && !req_taken)) begin
      if (req_idle > 0) begin
        req_valid <= 1'b0;
        req_idle <= req_idle - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        req_valid <= 1'b0;
        req_idle <= $urandom_range(0, 7);
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result side stalls in bursts
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (rsp_idle > 0) begin
      rsp_ready <= 1'b0;
      rsp_idle <= rsp_idle - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rsp_ready <= 1'b0;
      rsp_idle <= $urandom_range(0, 7);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  task automatic push_alloc(int unsigned bytes);
    req_t r;
    r.cmd = CMD_ALLOC;
    r.req_size = bytes[ADDR_W-1:0];
    r.block_addr = ADDR_W'($urandom());
    pending_reqs.push_back(r);
  endtask

  task automatic push_release(logic [ADDR_W-1:0] a);
    req_t r;
    r.cmd = CMD_RELEASE;
    r.req_size = ADDR_W'($urandom());
    r.block_addr = a;
    pending_reqs.push_back(r);
  endtask

  // wait until idle, then the block's own settling time
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [ADDR_W-1:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int n);
    int unsigned k, pick;
    for (int i = 0; i < n; i++) begin
      while (pending_reqs.size() > 1) @(posedge clk);
      k = $urandom_range(0, 99);
      if (k < 45) begin
        if ($urandom_range(0, 9) == 0) push_alloc($urandom() & 32'h1FFFFF);
        else if ($urandom_range(0, 9) == 0) push_alloc($urandom_range(0, 8000));
        else push_alloc($urandom_range(0, 200));
      end else if (k < 90 && live_addrs.size() > 0) begin
        pick = $urandom_range(0, live_addrs.size() - 1);
        push_release(live_addrs[pick]);
        // keep a few around so they get released twice
        if ($urandom_range(0, 7) != 0) live_addrs.delete(pick);
      end else if (k < 95) begin
        push_release(ADDR_W'($urandom()));
      end else begin
        push_release('0);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes of the sizes, split, exact fit, merge, release cases
    push_alloc(0);
    push_alloc(21'h1FFFFF);
    push_alloc(HEAP_BYTES);
    push_alloc(1);
    push_alloc(64);
    push_alloc(40);
    push_alloc(16);
    push_release('0);
    push_release(21'd5);
    push_release(21'h1FFFFF);
    wait_idle();
    // blocks at 24, 56, 144, 208
    push_release(21'd56);
    push_release(21'd56);
    push_release(21'd144);
    push_alloc(8);
    push_alloc(100);
    push_alloc(8);
    push_release(21'd208);
    push_release(21'd208);
    push_alloc(HEAP_BYTES - 400);
    push_alloc(HEAP_BYTES);
    push_alloc(7);
    wait_idle();

    // pressure: each setting drains fully before the next
    random_items(250);
    wait_idle();
    write_limit(21'd2000);
    random_items(250);
    wait_idle();
    write_limit('0);
    random_items(100);
    wait_idle();
    write_limit(21'h1FFFFF);
    random_items(250);
    wait_idle();
    write_limit(21'd300000);
    random_items(150);
    wait_idle();
    write_limit(21'd1048576);
    quiet = 1'b1;
    random_items(250);
    wait_idle();

    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// File: filelist.f
src/ffba_pkg.sv
src/ffba_mem.sv
src/first_fit_block_allocator.sv
dv/testbench.sv
